FILE: hdl/link_adaptation_controller_defines.svh
// Assertion helpers for the link adaptation controller checker.
`ifndef LINK_ADAPTATION_CONTROLLER_DEFINES_SVH
`define LINK_ADAPTATION_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LAC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("link adaptation check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LAC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("link adaptation check failed");

`endif

FILE: hdl/lac_pkg.sv
`default_nettype none

package lac_pkg;

	// Parameter defaults
	localparam int DEF_RATE_LEVELS  = 3;
	localparam int DEF_POWER_LEVELS = 5;
	localparam int DEF_TIME_BITS    = 48;

	// Fixed field widths
	localparam int NOW_W  = 48;
	localparam int CNT_W  = 16;
	localparam int INC_W  = 8;
	localparam int TOT_W  = 8;
	localparam int PM_W   = 10;
	localparam int TOUT_W = 48;

	// Configuration port
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// Loss divider: quotient is at most 1000, so ten quotient bits suffice
	localparam int DIV_STEPS = 10;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	// Register reset values
	localparam logic [TOT_W-1:0]  RST_N_DEFAULT = 8'd6;
	localparam logic [TOT_W-1:0]  RST_N_MAX     = 8'd10;
	localparam logic [PM_W-1:0]   RST_DEGRADE   = 10'd120;
	localparam logic [PM_W-1:0]   RST_RATE_DROP = 10'd350;
	localparam logic [PM_W-1:0]   RST_HOLD      = 10'd60;
	localparam logic [PM_W-1:0]   RST_CLEAN     = 10'd30;
	localparam logic [TOUT_W-1:0] RST_TIMEOUT   = 48'd5000000;

	typedef enum logic [2:0] {
		REG_N_DEFAULT = 3'd0,
		REG_N_MAX     = 3'd1,
		REG_DEGRADE   = 3'd2,
		REG_RATE_DROP = 3'd3,
		REG_HOLD      = 3'd4,
		REG_CLEAN     = 3'd5,
		REG_TIMEOUT   = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_REVERT  = 3'd1,
		ACT_DEGRADE = 3'd2,
		ACT_LIMIT   = 3'd3,
		ACT_HOLD    = 3'd4,
		ACT_PROBE   = 3'd5,
		ACT_SHED    = 3'd6,
		ACT_TRIM    = 3'd7
	} act_t;

	typedef struct packed {
		logic [TOT_W-1:0]  n_default;
		logic [TOT_W-1:0]  n_max;
		logic [PM_W-1:0]   degrade_pm;
		logic [PM_W-1:0]   rate_drop_pm;
		logic [PM_W-1:0]   hold_pm;
		logic [PM_W-1:0]   clean_pm;
		logic [TOUT_W-1:0] timeout_us;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic prep;
		logic div_step;
		logic commit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

FILE: hdl/lac_regs.sv
`default_nettype none

module lac_regs import lac_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Write the addressed register in the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.n_default    <= RST_N_DEFAULT;
			cfg_q.n_max        <= RST_N_MAX;
			cfg_q.degrade_pm   <= RST_DEGRADE;
			cfg_q.rate_drop_pm <= RST_RATE_DROP;
			cfg_q.hold_pm      <= RST_HOLD;
			cfg_q.clean_pm     <= RST_CLEAN;
			cfg_q.timeout_us   <= RST_TIMEOUT;
		end else if (wr_en) begin
			unique case (idx)
				REG_N_DEFAULT: cfg_q.n_default    <= pwdata[TOT_W-1:0];
				REG_N_MAX:     cfg_q.n_max        <= pwdata[TOT_W-1:0];
				REG_DEGRADE:   cfg_q.degrade_pm   <= pwdata[PM_W-1:0];
				REG_RATE_DROP: cfg_q.rate_drop_pm <= pwdata[PM_W-1:0];
				REG_HOLD:      cfg_q.hold_pm      <= pwdata[PM_W-1:0];
				REG_CLEAN:     cfg_q.clean_pm     <= pwdata[PM_W-1:0];
				REG_TIMEOUT:   cfg_q.timeout_us   <= pwdata[TOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (idx)
			REG_N_DEFAULT: prdata = DATA_W'(cfg_q.n_default);
			REG_N_MAX:     prdata = DATA_W'(cfg_q.n_max);
			REG_DEGRADE:   prdata = DATA_W'(cfg_q.degrade_pm);
			REG_RATE_DROP: prdata = DATA_W'(cfg_q.rate_drop_pm);
			REG_HOLD:      prdata = DATA_W'(cfg_q.hold_pm);
			REG_CLEAN:     prdata = DATA_W'(cfg_q.clean_pm);
			REG_TIMEOUT:   prdata = DATA_W'(cfg_q.timeout_us);
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/lac_ctrl.sv
`default_nettype none

module lac_ctrl import lac_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output cmd_t      cmd,
	input  status_t   status
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_PREP   = 4'b0010,
		S_DIV    = 4'b0100,
		S_DECIDE = 4'b1000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [DCNT_W-1:0] cnt_q;
	logic              last_step;

	assign last_step = (cnt_q == DCNT_W'(DIV_STEPS - 1));

	// Command decode
	always_comb begin
		cmd.capture  = (state_q == S_IDLE) && in_valid;
		cmd.prep     = (state_q == S_PREP);
		cmd.div_step = (state_q == S_DIV);
		cmd.commit   = (state_q == S_DECIDE) && status.out_free;
	end

	assign in_stall = (state_q != S_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_PREP;
			S_PREP:   state_d = S_DIV;
			S_DIV:    if (last_step) state_d = S_DECIDE;
			S_DECIDE: if (status.out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Advance state and divide step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				cnt_q <= last_step ? '0 : cnt_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/lac_dpath.sv
`default_nettype none

module lac_dpath import lac_pkg::*; #(
	parameter int RATE_LEVELS  = DEF_RATE_LEVELS,
	parameter int POWER_LEVELS = DEF_POWER_LEVELS,
	parameter int TIME_BITS    = DEF_TIME_BITS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  cfg_t                  cfg,
	input  cmd_t                  cmd,
	output status_t               status,
	input  wire logic             req_type,
	input  wire logic [NOW_W-1:0] now_us,
	input  wire logic [CNT_W-1:0] rx_expected,
	input  wire logic [CNT_W-1:0] rx_received,
	input  wire logic [INC_W-1:0] rx_incomplete,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [1:0]       rate_index,
	output logic      [2:0]       power_index,
	output logic      [5:0]       power_quarter_dbm,
	output logic      [TOT_W-1:0] parity_total,
	output logic      [2:0]       action
);

	localparam int RW    = $clog2(RATE_LEVELS);
	localparam int PW    = $clog2(POWER_LEVELS);
	localparam int TB    = TIME_BITS;
	localparam int NUM_W = CNT_W + PM_W;
	localparam int WIN_W = 7;

	localparam logic [RW-1:0]    RATE_TOP  = RW'(RATE_LEVELS - 1);
	localparam logic [PW-1:0]    PWR_CAP   = PW'(POWER_LEVELS - 1);
	localparam logic [PW-1:0]    PWR_DEF   = PW'(POWER_LEVELS - 2);
	localparam logic [WIN_W-1:0] WIN_BASE  = 7'd5;
	localparam logic [WIN_W-1:0] WIN_CAP   = 7'd60;
	localparam logic [WIN_W-1:0] WIN_DBL   = 7'd30;
	localparam logic [31:0]      FAIL_US   = 32'd5000000;
	localparam logic [31:0]      FORGIVE_US = 32'd30000000;
	localparam logic [PM_W-1:0]  LOSS_SCALE = 10'd1000;

	// Item capture
	logic             item_req_q;
	logic [TB-1:0]    item_now_q;
	logic [CNT_W-1:0] item_exp_q;
	logic [CNT_W-1:0] item_got_q;
	logic [INC_W-1:0] item_inc_q;

	// Link state
	logic [TB-1:0]    fb_time_q;
	logic             fb_seen_q;
	logic [CNT_W-1:0] st_exp_q;
	logic [CNT_W-1:0] st_got_q;
	logic [INC_W-1:0] st_inc_q;
	logic [RW-1:0]    rate_q;
	logic [PW-1:0]    pwr_q;
	logic [TOT_W-1:0] total_q;
	logic [7:0]       good_q;
	logic [7:0]       clean_q;
	logic [WIN_W-1:0] win_q;
	logic [TB-1:0]    probe_time_q;
	logic             probe_armed_q;

	// Prep results and divider
	logic             stale_q;
	logic             probe_fail_q;
	logic             probe_forgive_q;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsh_q;
	logic [PM_W-1:0]  quot_q;

	// Next state from the decide step
	logic [RW-1:0]    rate_d;
	logic [PW-1:0]    pwr_d;
	logic [TOT_W-1:0] total_d;
	logic [7:0]       good_d;
	logic [7:0]       clean_d;
	logic [WIN_W-1:0] win_d;
	logic             probe_set;
	logic             probe_clr;
	act_t             act_d;

	// Output register
	logic             out_valid_q;
	logic [RW-1:0]    out_rate_q;
	logic [PW-1:0]    out_pwr_q;
	logic [TOT_W-1:0] out_total_q;
	act_t             out_act_q;

	// Prep combinational terms
	logic [TB-1:0]    fb_age;
	logic [TB-1:0]    probe_age;
	logic [CNT_W-1:0] got_clamp;
	logic [CNT_W-1:0] missing;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	assign status.out_free = !out_valid_q || !out_stall;

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_req_q <= req_type;
			item_now_q <= TB'(now_us);
			item_exp_q <= rx_expected;
			item_got_q <= rx_received;
			item_inc_q <= rx_incomplete;
		end
	end

	// Ages, staleness and loss numerator
	always_comb begin
		fb_age    = item_now_q - fb_time_q;
		probe_age = item_now_q - probe_time_q;
		got_clamp = (st_got_q > st_exp_q) ? st_exp_q : st_got_q;
		missing   = st_exp_q - got_clamp;
	end

	// Prep, then restoring divide one quotient bit a step
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			stale_q         <= !fb_seen_q || (64'(fb_age) >= 64'(cfg.timeout_us));
			probe_fail_q    <= probe_age < TB'(FAIL_US);
			probe_forgive_q <= probe_age > TB'(FORGIVE_US);
			rem_q           <= NUM_W'(missing) * NUM_W'(LOSS_SCALE);
			dsh_q           <= NUM_W'(st_exp_q) << (DIV_STEPS - 1);
			quot_q          <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= dsh_q) begin
				rem_q  <= rem_q - dsh_q;
				quot_q <= {quot_q[PM_W-2:0], 1'b1};
			end else begin
				quot_q <= {quot_q[PM_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	// Adapt the link for a tick
	always_comb begin
		rate_d    = rate_q;
		pwr_d     = pwr_q;
		total_d   = total_q;
		good_d    = good_q;
		clean_d   = clean_q;
		win_d     = win_q;
		probe_set = 1'b0;
		probe_clr = 1'b0;
		act_d     = ACT_NONE;
		if (!item_req_q) begin
			act_d = ACT_NONE;
		end else if (stale_q) begin
			// Revert to defaults; report only if something moved
			if (rate_q != RATE_TOP || total_q != cfg.n_default || pwr_q != PWR_DEF) begin
				rate_d  = RATE_TOP;
				pwr_d   = PWR_DEF;
				total_d = cfg.n_default;
				act_d   = ACT_REVERT;
			end
			good_d = '0;
		end else if (st_exp_q == '0) begin
			act_d = ACT_NONE;
		end else if (quot_q > cfg.degrade_pm || st_inc_q != '0) begin
			good_d  = '0;
			clean_d = '0;
			// Back off the probe window after a failed probe
			if (probe_armed_q && probe_fail_q) begin
				win_d     = (win_q >= WIN_DBL) ? WIN_CAP : {win_q[WIN_W-2:0], 1'b0};
				probe_clr = 1'b1;
			end
			act_d = ACT_DEGRADE;
			if (pwr_q < PWR_CAP) begin
				pwr_d = pwr_q + 1'b1;
			end else if (quot_q > cfg.rate_drop_pm && rate_q != '0) begin
				rate_d = rate_q - 1'b1;
			end else if ((9'(total_q) + 9'd2) <= 9'(cfg.n_max)) begin
				total_d = total_q + 8'd2;
			end else if (rate_q != '0) begin
				rate_d = rate_q - 1'b1;
			end else begin
				act_d = ACT_LIMIT;
			end
		end else if (quot_q >= cfg.hold_pm) begin
			good_d  = '0;
			clean_d = '0;
			act_d   = ACT_HOLD;
		end else begin
			clean_d = sat_inc(clean_q);
			good_d  = (quot_q >= cfg.clean_pm) ? 8'd0 : sat_inc(good_q);
			if (rate_q < RATE_TOP && good_d >= 8'(win_q)) begin
				// Probe the next rate with extra power
				good_d    = '0;
				pwr_d     = ((PW + 1)'(pwr_q) + (PW + 1)'(2) > (PW + 1)'(PWR_CAP)) ?
				            PWR_CAP : pwr_q + PW'(2);
				rate_d    = rate_q + 1'b1;
				probe_set = 1'b1;
				act_d     = ACT_PROBE;
			end else begin
				// Forgive an old probe once back on the top rate
				if (rate_q == RATE_TOP && win_q != WIN_BASE && probe_armed_q &&
				    probe_forgive_q) begin
					win_d = WIN_BASE;
				end
				if (total_q > cfg.n_default && good_d >= 8'd5) begin
					good_d  = '0;
					total_d = (total_q >= 8'd2) ? total_q - 8'd2 : cfg.n_default;
					act_d   = ACT_SHED;
				end else if (pwr_q != '0 && clean_d >= 8'd2) begin
					clean_d = '0;
					pwr_d   = pwr_q - 1'b1;
					act_d   = ACT_TRIM;
				end
			end
		end
	end

	// Commit the item's effect on the link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_time_q     <= '0;
			fb_seen_q     <= 1'b0;
			st_exp_q      <= '0;
			st_got_q      <= '0;
			st_inc_q      <= '0;
			rate_q        <= RATE_TOP;
			pwr_q         <= PWR_DEF;
			total_q       <= RST_N_DEFAULT;
			good_q        <= '0;
			clean_q       <= '0;
			win_q         <= WIN_BASE;
			probe_time_q  <= '0;
			probe_armed_q <= 1'b0;
		end else if (cmd.commit) begin
			if (!item_req_q) begin
				fb_time_q <= item_now_q;
				fb_seen_q <= 1'b1;
				st_exp_q  <= item_exp_q;
				st_got_q  <= item_got_q;
				st_inc_q  <= item_inc_q;
			end
			rate_q  <= rate_d;
			pwr_q   <= pwr_d;
			total_q <= total_d;
			good_q  <= good_d;
			clean_q <= clean_d;
			win_q   <= win_d;
			if (probe_set) begin
				probe_time_q  <= item_now_q;
				probe_armed_q <= 1'b1;
			end else if (probe_clr) begin
				probe_armed_q <= 1'b0;
			end
		end
	end

	// Output register: load on commit, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_rate_q  <= rate_d;
			out_pwr_q   <= pwr_d;
			out_total_q <= total_d;
			out_act_q   <= act_d;
		end
	end

	// Drive result fields, masked to their port widths
	logic [2:0] rate_w;
	logic [2:0] pwr_w;
	logic [2:0] pwr_step;

	always_comb begin
		rate_w   = 3'(out_rate_q);
		pwr_w    = 3'(out_pwr_q);
		pwr_step = pwr_w + 3'd1;
	end

	assign out_valid         = out_valid_q;
	assign rate_index        = rate_w[1:0];
	assign power_index       = pwr_w;
	assign power_quarter_dbm = {pwr_step, 3'b000};
	assign parity_total      = out_total_q;
	assign action            = out_act_q;

endmodule

`default_nettype wire

FILE: hdl/link_adaptation_controller.sv
`default_nettype none

// Link adaptation controller. Feedback items (req_type 0) latch the receiver
// report and its arrival time; tick items (req_type 1) revert, degrade, hold
// or recover the rate, TX power and FEC parity, and every item returns one
// result with the current settings and the action taken. An item holds the
// input from the transfer cycle through the prep state (feedback and probe
// ages, the 16x10 loss multiply), the restoring loss divider (ten quotient
// bits, one quotient bit per cycle, quotient at most 1000) and the decide
// state, which loads the result into the output register. The next item is
// taken the cycle after the result is loaded, so no item is accepted while
// the last is in progress; a stalled result holds the decide state and with
// it the input.
// Configuration sits on an APB port with 64-bit data, register i at byte
// address 8*i; write it only while the block is idle.
module link_adaptation_controller import lac_pkg::*; #(
	parameter int RATE_LEVELS  = DEF_RATE_LEVELS,
	parameter int POWER_LEVELS = DEF_POWER_LEVELS,
	parameter int TIME_BITS    = DEF_TIME_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              req_type,
	input  wire logic [NOW_W-1:0]  now_us,
	input  wire logic [CNT_W-1:0]  rx_expected,
	input  wire logic [CNT_W-1:0]  rx_received,
	input  wire logic [INC_W-1:0]  rx_incomplete,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [1:0]        rate_index,
	output logic      [2:0]        power_index,
	output logic      [5:0]        power_quarter_dbm,
	output logic      [TOT_W-1:0]  parity_total,
	output logic      [2:0]        action
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	lac_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status)
	);

	lac_dpath #(
		.RATE_LEVELS  (RATE_LEVELS),
		.POWER_LEVELS (POWER_LEVELS),
		.TIME_BITS    (TIME_BITS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.status            (status),
		.req_type          (req_type),
		.now_us            (now_us),
		.rx_expected       (rx_expected),
		.rx_received       (rx_received),
		.rx_incomplete     (rx_incomplete),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.rate_index        (rate_index),
		.power_index       (power_index),
		.power_quarter_dbm (power_quarter_dbm),
		.parity_total      (parity_total),
		.action            (action)
	);

endmodule

`default_nettype wire

FILE: hdl/lac_checker.sv
`default_nettype none

`include "link_adaptation_controller_defines.svh"

module lac_checker import lac_pkg::*; #(
	parameter int RATE_LEVELS  = DEF_RATE_LEVELS,
	parameter int POWER_LEVELS = DEF_POWER_LEVELS
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [1:0]        rate_index,
	input wire logic [2:0]        power_index,
	input wire logic [5:0]        power_quarter_dbm,
	input wire logic [TOT_W-1:0]  parity_total,
	input wire logic [2:0]        action
);

	localparam logic [1:0] RATE_TOP_W = 2'(RATE_LEVELS - 1);
	localparam logic [2:0] PWR_DEF_W  = 3'(POWER_LEVELS - 2);

	// A stalled result holds
	`LAC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(action) && $stable(parity_total) && $stable(rate_index))

	// The block works on one item at a time
	`LAC_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)

	// A revert lands on the default rate and power
	`LAC_ASSERT_SAME(a_revert_defaults, out_valid && action == ACT_REVERT,
		rate_index == RATE_TOP_W && power_index == PWR_DEF_W)

	// Power in quarter dBm tracks the power rung
	`LAC_ASSERT_SAME(a_power_ladder, out_valid,
		power_quarter_dbm == {power_index + 3'd1, 3'b000})

endmodule

bind link_adaptation_controller lac_checker #(
	.RATE_LEVELS  (RATE_LEVELS),
	.POWER_LEVELS (POWER_LEVELS)
) u_lac_checker (.*);

`default_nettype wire

FILE: test/tb_link_adaptation_controller.sv
module tb_link_adaptation_controller;
	import lac_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Request kinds on req_type
	localparam logic REQ_FEEDBACK = 1'b0;
	localparam logic REQ_TICK     = 1'b1;

	// Ladder limits and probe timing
	localparam logic [1:0]       RATE_TOP         = 2'(DEF_RATE_LEVELS - 1);
	localparam logic [2:0]       PWR_CAP          = 3'(DEF_POWER_LEVELS - 1);
	localparam logic [2:0]       PWR_DEF          = 3'(DEF_POWER_LEVELS - 2);
	localparam logic [NOW_W-1:0] PROBE_FAIL_US    = 48'd5_000_000;
	localparam logic [NOW_W-1:0] PROBE_FORGIVE_US = 48'd30_000_000;
	localparam logic [6:0]       WIN_BASE         = 7'd5;
	localparam logic [6:0]       WIN_MAX          = 7'd60;

	// Run shape
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 255;
	localparam int CHOKE_CYCLES  = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_LIMIT   = 20000;

	typedef struct packed {
		logic             req;
		logic [NOW_W-1:0] now;
		logic [CNT_W-1:0] exp;
		logic [CNT_W-1:0] rcv;
		logic [INC_W-1:0] inc;
	} link_req_t;

	typedef struct packed {
		logic [1:0]       rate;
		logic [2:0]       pwr;
		logic [5:0]       dbm;
		logic [TOT_W-1:0] total;
		act_t             act;
	} link_status_t;

	typedef struct {
		link_req_t    rq;
		bit           typed;
		link_status_t want;
	} plan_row_t;

	typedef enum logic [1:0] {
		GRADE_CLEAN,
		GRADE_MARGINAL,
		GRADE_POOR,
		GRADE_ERRATIC
	} channel_grade_t;

	logic              clk;
	logic              arst_n            = 1'b0;
	logic              psel              = 1'b0;
	logic              penable           = 1'b0;
	logic              pwrite            = 1'b0;
	logic [ADDR_W-1:0] paddr             = '0;
	logic [DATA_W-1:0] pwdata            = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid          = 1'b0;
	logic              in_stall;
	logic              req_type          = 1'b0;
	logic [NOW_W-1:0]  now_us            = '0;
	logic [CNT_W-1:0]  rx_expected       = '0;
	logic [CNT_W-1:0]  rx_received       = '0;
	logic [INC_W-1:0]  rx_incomplete     = '0;
	logic              out_valid;
	logic              out_stall         = 1'b0;
	logic [1:0]        rate_index;
	logic [2:0]        power_index;
	logic [5:0]        power_quarter_dbm;
	logic [TOT_W-1:0]  parity_total;
	logic [2:0]        action;

	// Shadow of the controller: settings and link state
	cfg_t             cfg_q;
	logic [NOW_W-1:0] fb_stamp;
	logic [NOW_W-1:0] probe_stamp;
	logic             fb_seen;
	logic             probe_armed_q;
	logic [CNT_W-1:0] rpt_exp;
	logic [CNT_W-1:0] rpt_rcv;
	logic [INC_W-1:0] rpt_inc;
	logic [1:0]       rate_q;
	logic [2:0]       pwr_q;
	logic [TOT_W-1:0] total_q;
	logic [7:0]       good_q;
	logic [7:0]       clean_q;
	logic [6:0]       win_q;

	link_status_t   pending_status[$];
	int             error_count = 0;
	bit             calm        = 1'b0;
	bit             choke_req   = 1'b0;
	logic [NOW_W-1:0] sim_now   = '0;
	channel_grade_t link_grade  = GRADE_CLEAN;

	link_adaptation_controller dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		error_count++;
		$display("MISMATCH @%0t: %s", $realtime, what);
	endtask

	function automatic void reset_link_model();
		cfg_q = '{RST_N_DEFAULT, RST_N_MAX, RST_DEGRADE, RST_RATE_DROP,
			RST_HOLD, RST_CLEAN, RST_TIMEOUT};
		fb_stamp = '0;
		probe_stamp = '0;
		fb_seen = 1'b0;
		probe_armed_q = 1'b0;
		rpt_exp = '0;
		rpt_rcv = '0;
		rpt_inc = '0;
		rate_q = RATE_TOP;
		pwr_q = PWR_DEF;
		total_q = RST_N_DEFAULT;
		good_q = '0;
		clean_q = '0;
		win_q = WIN_BASE;
	endfunction

	function automatic logic [7:0] sat_bump(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	// One adaptation tick: revert, degrade, hold or recover
	function automatic act_t adapt_link(input logic [NOW_W-1:0] now);
		logic [NOW_W-1:0] fb_age;
		logic [NOW_W-1:0] probe_age;
		logic [CNT_W-1:0] got;
		int unsigned      loss;
		act_t             verdict;
		fb_age = now - fb_stamp;
		probe_age = now - probe_stamp;
		verdict = ACT_NONE;

		// stale or missing feedback: fall back to defaults
		if (!fb_seen || fb_age >= cfg_q.timeout_us) begin
			if (rate_q != RATE_TOP || total_q != cfg_q.n_default || pwr_q != PWR_DEF) begin
				rate_q = RATE_TOP;
				pwr_q = PWR_DEF;
				total_q = cfg_q.n_default;
				verdict = ACT_REVERT;
			end
			good_q = '0;
			return verdict;
		end
		if (rpt_exp == '0) return ACT_NONE;

		got = (rpt_rcv > rpt_exp) ? rpt_exp : rpt_rcv;
		loss = (32'd1000 * 32'(rpt_exp - got)) / 32'(rpt_exp);

		// degrade one step: power, rate at heavy loss, parity, rate
		if (loss > cfg_q.degrade_pm || rpt_inc != '0) begin
			good_q = '0;
			clean_q = '0;
			if (probe_armed_q && probe_age < PROBE_FAIL_US) begin
				win_q = (win_q >= 7'd30) ? WIN_MAX : win_q << 1;
				probe_armed_q = 1'b0;
			end
			if (pwr_q < PWR_CAP) pwr_q = pwr_q + 3'd1;
			else if (loss > cfg_q.rate_drop_pm && rate_q > 0) rate_q = rate_q - 2'd1;
			else if (9'(total_q) + 9'd2 <= 9'(cfg_q.n_max)) total_q = total_q + 8'd2;
			else if (rate_q > 0) rate_q = rate_q - 2'd1;
			else return ACT_LIMIT;
			return ACT_DEGRADE;
		end

		if (loss >= cfg_q.hold_pm) begin
			good_q = '0;
			clean_q = '0;
			return ACT_HOLD;
		end
		clean_q = sat_bump(clean_q);
		if (loss >= cfg_q.clean_pm) good_q = '0;
		else good_q = sat_bump(good_q);

		// rate probe once the back-off window has passed
		if (rate_q < RATE_TOP && good_q >= 8'(win_q)) begin
			good_q = '0;
			pwr_q = (int'(pwr_q) + 2 > int'(PWR_CAP)) ? PWR_CAP : pwr_q + 3'd2;
			rate_q = rate_q + 2'd1;
			probe_stamp = now;
			probe_armed_q = 1'b1;
			return ACT_PROBE;
		end

		// forgive an old probe failure
		if (rate_q == RATE_TOP && win_q != WIN_BASE && probe_armed_q &&
				probe_age > PROBE_FORGIVE_US) begin
			win_q = WIN_BASE;
		end

		if (total_q > cfg_q.n_default && good_q >= 8'd5) begin
			good_q = '0;
			total_q = (total_q >= 8'd2) ? total_q - 8'd2 : cfg_q.n_default;
			return ACT_SHED;
		end
		if (pwr_q > 0 && clean_q >= 8'd2) begin
			clean_q = '0;
			pwr_q = pwr_q - 3'd1;
			return ACT_TRIM;
		end
		return ACT_NONE;
	endfunction

	// Apply one item to the shadow and return the status it reports
	function automatic link_status_t advance_link(input link_req_t rq);
		link_status_t st;
		act_t         verdict;
		verdict = ACT_NONE;
		if (rq.req == REQ_FEEDBACK) begin
			rpt_exp = rq.exp;
			rpt_rcv = rq.rcv;
			rpt_inc = rq.inc;
			fb_stamp = rq.now;
			fb_seen = 1'b1;
		end else begin
			verdict = adapt_link(rq.now);
		end
		st.rate = rate_q;
		st.pwr = pwr_q;
		st.dbm = 6'((int'(pwr_q) + 1) * 8);
		st.total = total_q;
		st.act = verdict;
		return st;
	endfunction

	function automatic plan_row_t stim_row(input logic kind, input logic [NOW_W-1:0] at,
			input logic [CNT_W-1:0] e, input logic [CNT_W-1:0] r,
			input logic [INC_W-1:0] inc, input bit typed = 1'b0,
			input logic [1:0] rate = '0, input logic [2:0] pwr = '0,
			input logic [5:0] dbm = '0, input logic [TOT_W-1:0] total = '0,
			input act_t act = ACT_NONE);
		plan_row_t row;
		row.rq = '{kind, at, e, r, inc};
		row.typed = typed;
		row.want = '{rate, pwr, dbm, total, act};
		return row;
	endfunction

	// Random traffic: a drifting channel grade shapes the reported loss
	function automatic link_req_t random_item();
		link_req_t    rq;
		int unsigned  roll;
		int unsigned  pm;
		int unsigned  lost;
		logic [63:0]  wide;
		if ($urandom_range(0, 99) < 4) begin
			roll = $urandom_range(0, 99);
			link_grade = (roll < 55) ? GRADE_CLEAN : (roll < 75) ? GRADE_MARGINAL :
				(roll < 90) ? GRADE_POOR : GRADE_ERRATIC;
		end

		// advance time: mostly forward, sometimes still, far, backwards or anywhere
		roll = $urandom_range(0, 99);
		wide = {$urandom(), $urandom()};
		if (roll < 3) sim_now = sim_now;
		else if (roll < 6) sim_now = sim_now + 48'($urandom_range(5_000_000, 40_000_000));
		else if (roll < 8) sim_now = sim_now - 48'($urandom_range(1, 10_000_000));
		else if (roll < 9) sim_now = wide[NOW_W-1:0];
		else sim_now = sim_now + 48'($urandom_range(1, 600_000));

		rq.now = sim_now;
		rq.req = ($urandom_range(0, 99) < 45) ? REQ_FEEDBACK : REQ_TICK;

		case (link_grade)
			GRADE_CLEAN: begin
				pm = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 29) : $urandom_range(0, 60);
			end
			GRADE_MARGINAL: pm = $urandom_range(0, 150);
			GRADE_POOR:     pm = $urandom_range(100, 1000);
			default:        pm = $urandom_range(0, 1000);
		endcase

		roll = $urandom_range(0, 99);
		if (roll < 3) rq.exp = '0;
		else if (roll < 8) rq.exp = 16'($urandom_range(0, 65535));
		else if (roll < 10) rq.exp = 16'hFFFF;
		else rq.exp = 16'($urandom_range(1, 3000));

		lost = (32'(rq.exp) * pm) / 1000;
		rq.rcv = 16'(32'(rq.exp) - lost);
		if ($urandom_range(0, 99) < 6) rq.rcv = 16'($urandom_range(0, 65535));

		roll = $urandom_range(0, 99);
		case (link_grade)
			GRADE_CLEAN:    rq.inc = (roll < 2) ? 8'($urandom_range(1, 255)) : '0;
			GRADE_MARGINAL: rq.inc = (roll < 3) ? 8'($urandom_range(1, 255)) : '0;
			default:        rq.inc = (roll < 15) ? 8'($urandom_range(1, 255)) : '0;
		endcase
		return rq;
	endfunction

	function automatic cfg_t pick_setting(input int phase);
		cfg_t        c;
		logic [63:0] wide;
		wide = {$urandom(), $urandom()};
		c = '{RST_N_DEFAULT, RST_N_MAX, RST_DEGRADE, RST_RATE_DROP,
			RST_HOLD, RST_CLEAN, RST_TIMEOUT};
		case (phase)
			0: c = '{8'd1, 8'd1, 10'd0, 10'd0, 10'd0, 10'd0, 48'd1};
			1: c = '{8'd255, 8'd255, 10'd1000, 10'd1000, 10'd1000, 10'd1000, {TOUT_W{1'b1}}};
			2: c = '{8'd4, 8'd16, 10'd200, 10'd500, 10'd80, 10'd20, 48'd3_000_000};
			3: begin
				c.n_default = 8'($urandom_range(1, 12));
				c.n_max = 8'($urandom_range(4, 40));
				c.degrade_pm = 10'($urandom_range(50, 400));
				c.rate_drop_pm = 10'($urandom_range(200, 1000));
				c.hold_pm = 10'($urandom_range(20, 150));
				c.clean_pm = 10'($urandom_range(0, 60));
				c.timeout_us = 48'($urandom_range(1_000_000, 20_000_000));
			end
			4: begin
				c.n_default = 8'($urandom_range(1, 255));
				c.n_max = 8'($urandom_range(1, 255));
				c.degrade_pm = 10'($urandom_range(0, 1000));
				c.rate_drop_pm = 10'($urandom_range(0, 1000));
				c.hold_pm = 10'($urandom_range(0, 1000));
				c.clean_pm = 10'($urandom_range(0, 1000));
				c.timeout_us = (wide[NOW_W-1:0] == '0) ? 48'd1 : wide[NOW_W-1:0];
			end
			default: c = c;
		endcase
		return c;
	endfunction

	// Write one register, read it back, update the shadow
	task automatic write_register(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		logic [DATA_W-1:0] kept;
		logic [DATA_W-1:0] seen;
		case (idx)
			REG_N_DEFAULT: begin
				kept = 64'(val[TOT_W-1:0]);
				cfg_q.n_default = val[TOT_W-1:0];
			end
			REG_N_MAX: begin
				kept = 64'(val[TOT_W-1:0]);
				cfg_q.n_max = val[TOT_W-1:0];
			end
			REG_DEGRADE: begin
				kept = 64'(val[PM_W-1:0]);
				cfg_q.degrade_pm = val[PM_W-1:0];
			end
			REG_RATE_DROP: begin
				kept = 64'(val[PM_W-1:0]);
				cfg_q.rate_drop_pm = val[PM_W-1:0];
			end
			REG_HOLD: begin
				kept = 64'(val[PM_W-1:0]);
				cfg_q.hold_pm = val[PM_W-1:0];
			end
			REG_CLEAN: begin
				kept = 64'(val[PM_W-1:0]);
				cfg_q.clean_pm = val[PM_W-1:0];
			end
			REG_TIMEOUT: begin
				kept = 64'(val[TOUT_W-1:0]);
				cfg_q.timeout_us = val[TOUT_W-1:0];
			end
			default: kept = '0;
		endcase

		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		seen = prdata;
		if (seen !== kept) begin
			flag_mismatch($sformatf("register %s read %0h want %0h", idx.name(), seen, kept));
		end
	endtask

	task automatic load_settings(input cfg_t c);
		write_register(REG_N_DEFAULT, 64'(c.n_default));
		write_register(REG_N_MAX, 64'(c.n_max));
		write_register(REG_DEGRADE, 64'(c.degrade_pm));
		write_register(REG_RATE_DROP, 64'(c.rate_drop_pm));
		write_register(REG_HOLD, 64'(c.hold_pm));
		write_register(REG_CLEAN, 64'(c.clean_pm));
		write_register(REG_TIMEOUT, 64'(c.timeout_us));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer one item, hold it until the transfer, then log its expected status
	task automatic offer(input link_req_t rq, input bit typed, input link_status_t want);
		link_status_t predicted;
		while (!calm && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq.req;
		now_us <= rq.now;
		rx_expected <= rq.exp;
		rx_received <= rq.rcv;
		rx_incomplete <= rq.inc;
		do @(posedge clk); while (in_stall);
		predicted = advance_link(rq);
		pending_status.push_back(typed ? want : predicted);
	endtask

	// Wait for every expected status, then let the pipeline go quiet
	task automatic settle();
		for (int k = 0; k < DRAIN_LIMIT && pending_status.size() != 0; k++) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver back-pressure: random stalls, one long choke on request
	initial begin : drive_out_stall
		forever begin
			@(posedge clk);
			if (choke_req) begin
				choke_req = 1'b0;
				out_stall <= 1'b1;
				repeat (CHOKE_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 35);
			end
		end
	end

	// Compare each status transfer against the oldest expectation
	always @(posedge clk) begin : check_status
		link_status_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_status.size() == 0) begin
				flag_mismatch("status transfer with nothing expected");
			end else begin
				want = pending_status.pop_front();
				if (rate_index !== want.rate)
					flag_mismatch($sformatf("rate_index %0d want %0d", rate_index, want.rate));
				if (power_index !== want.pwr)
					flag_mismatch($sformatf("power_index %0d want %0d", power_index, want.pwr));
				if (power_quarter_dbm !== want.dbm)
					flag_mismatch($sformatf("power_quarter_dbm %0d want %0d",
						power_quarter_dbm, want.dbm));
				if (parity_total !== want.total)
					flag_mismatch($sformatf("parity_total %0d want %0d", parity_total, want.total));
				if (action !== want.act)
					flag_mismatch($sformatf("action %0d want %s", action, want.act.name()));
			end
		end
	end

	initial begin : stimulus
		plan_row_t plan[$];
		reset_link_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: defaults, degrade ladder to the limit, edge reports, time wrap
		plan.push_back(stim_row(REQ_TICK, 48'd0, 16'd0, 16'd0, 8'd0,
			1'b1, 2'd2, 3'd3, 6'd32, 8'd6, ACT_NONE));
		plan.push_back(stim_row(REQ_FEEDBACK, 48'd1_000, 16'd1000, 16'd1000, 8'd0,
			1'b1, 2'd2, 3'd3, 6'd32, 8'd6, ACT_NONE));
		plan.push_back(stim_row(REQ_TICK, 48'd1_000_000, 16'd0, 16'd0, 8'd0));
		plan.push_back(stim_row(REQ_TICK, 48'd2_000_000, 16'd0, 16'd0, 8'd0));
		plan.push_back(stim_row(REQ_FEEDBACK, 48'd2_100_000, 16'hFFFF, 16'd0, 8'd0));
		for (int k = 0; k < 6; k++) begin
			plan.push_back(stim_row(REQ_TICK, 48'd2_200_000 + 48'(k) * 48'd100_000,
				16'd0, 16'd0, 8'd0));
		end
		plan.push_back(stim_row(REQ_TICK, 48'd2_800_000, 16'd0, 16'd0, 8'd0,
			1'b1, 2'd0, 3'd4, 6'd40, 8'd10, ACT_LIMIT));
		// no chunks expected: nothing to measure
		plan.push_back(stim_row(REQ_FEEDBACK, 48'd2_900_000, 16'd0, 16'hFFFF, 8'd0));
		plan.push_back(stim_row(REQ_TICK, 48'd3_000_000, 16'd0, 16'd0, 8'd0,
			1'b1, 2'd0, 3'd4, 6'd40, 8'd10, ACT_NONE));
		// more received than expected: clamps to zero loss
		plan.push_back(stim_row(REQ_FEEDBACK, 48'd3_100_000, 16'd100, 16'hFFFF, 8'd0));
		plan.push_back(stim_row(REQ_TICK, 48'd3_200_000, 16'd0, 16'd0, 8'd0));
		plan.push_back(stim_row(REQ_FEEDBACK, 48'd3_300_000, 16'd1000, 16'd930, 8'd0));
		plan.push_back(stim_row(REQ_TICK, 48'd3_400_000, 16'd0, 16'd0, 8'd0,
			1'b1, 2'd0, 3'd4, 6'd40, 8'd10, ACT_HOLD));
		plan.push_back(stim_row(REQ_FEEDBACK, 48'd3_500_000, 16'd1000, 16'd960, 8'd0));
		plan.push_back(stim_row(REQ_TICK, 48'd3_600_000, 16'd0, 16'd0, 8'd0));
		// incomplete frames force a degrade even at zero loss
		plan.push_back(stim_row(REQ_FEEDBACK, 48'd3_700_000, 16'd1000, 16'd1000, 8'hFF));
		plan.push_back(stim_row(REQ_TICK, 48'd3_800_000, 16'd0, 16'd0, 8'd0,
			1'b1, 2'd0, 3'd4, 6'd40, 8'd10, ACT_LIMIT));
		// time going backwards looks stale
		plan.push_back(stim_row(REQ_TICK, 48'd1_000, 16'd0, 16'd0, 8'd0,
			1'b1, 2'd2, 3'd3, 6'd32, 8'd6, ACT_REVERT));
		// wrap of the microsecond counter, then age exactly at the timeout
		plan.push_back(stim_row(REQ_FEEDBACK, {NOW_W{1'b1}}, 16'd1000, 16'd1000, 8'd0));
		plan.push_back(stim_row(REQ_TICK, 48'h1000, 16'hFFFF, 16'hFFFF, 8'hFF));
		plan.push_back(stim_row(REQ_TICK, 48'd4_999_999, 16'd0, 16'd0, 8'd0,
			1'b1, 2'd2, 3'd3, 6'd32, 8'd6, ACT_NONE));
		foreach (plan[i]) offer(plan[i].rq, plan[i].typed, plan[i].want);

		// Random phases, each under its own settings
		for (int p = 0; p < PHASES; p++) begin
			in_valid <= 1'b0;
			settle();
			load_settings(pick_setting(p));
			if (p == 2) choke_req = 1'b1;
			calm = (p == PHASES - 1);
			for (int k = 0; k < PHASE_ITEMS; k++) offer(random_item(), 1'b0, '0);
		end
		in_valid <= 1'b0;
		calm = 1'b0;
		settle();

		if (pending_status.size() != 0) begin
			flag_mismatch($sformatf("%0d status transfers never arrived", pending_status.size()));
		end
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
